@@ hw/rtl/rau_pkg.sv @@
// Shared types and codes for the rational arithmetic unit.
// No dependencies; imported by the divider, the gcd unit and the top level.
`timescale 1ns / 1ps

package rau_pkg;

  localparam int RES_W = 32;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_SUB   = 3'd1;
  localparam logic [2:0] CMD_MUL   = 3'd2;
  localparam logic [2:0] CMD_DIV   = 3'd3;
  localparam logic [2:0] CMD_RECIP = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [1:0] STAT_ZERO_DIV = 2'd2;
  localparam logic [1:0] STAT_OVF      = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_AB,
    S_DIV_BA,
    S_MUL_C,
    S_MUL_TA,
    S_MUL_TB,
    S_SUM,
    S_MUL_N,
    S_MUL_D,
    S_CHECK,
    S_GCD,
    S_DIV_N,
    S_DIV_D,
    S_OUT
  } state_t;

  // Handshake status of an iterative unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ hw/rtl/rau_div.sv @@
// Restoring divider, one quotient bit per cycle, for unsigned magnitudes.
// Depends on rau_pkg for the unit status struct.
`timescale 1ns / 1ps

module rau_div import rau_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem,
  output unit_stat_t   stat
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [W:0]    sh;
  logic [W:0]    diff;

  assign sh   = {rem, quo[W-1]};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CW'(W);
      end else if (stat.busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (stat.busy) begin
      // keep the remainder when the trial subtract borrows
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hw/rtl/rau_gcd.sv @@
// Binary gcd of two unsigned magnitudes, one shift or subtract per cycle.
// Depends on rau_pkg for the unit status struct.
`timescale 1ns / 1ps

module rau_gcd import rau_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x_in,
  input  logic [W-1:0] y_in,
  output logic [W-1:0] g,
  output unit_stat_t   stat
);

  localparam int KW = $clog2(W + 1);

  logic [W-1:0]  x;
  logic [W-1:0]  y;
  logic [KW-1:0] k;
  logic          fin;

  assign fin = (x == '0) || (y == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && fin) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_in;
      y <= y_in;
      k <= '0;
    end else if (stat.busy) begin
      if (fin) begin
        g <= (x | y) << k;
      end else if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= k + KW'(1);
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x > y) begin
        x <= x - y;
      end else begin
        y <= y - x;
      end
    end
  end

  gcd_nonzero_a: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> g != '0)
    else $error("gcd result is zero");

endmodule

@@ hw/rtl/rational_arith_unit.sv @@
// Top level of the rational arithmetic unit: sequencer, shared multiplier
// and result register. Uses rau_pkg, rau_div and rau_gcd.
`timescale 1ns / 1ps
//
// channel  dir  tdata (low bit up)                  tuser
// s_*      in   a_num, a_den, b_num, b_den          command
// m_*      out  res_num, res_den                    status
//
// One request at a time; s_tready is high only while the sequencer is idle.
// After acceptance, add/subtract run two divides of the input denominators, the
// common-denominator multiplies and the sum; multiply/divide run two multiplies;
// reciprocal swaps the operand; each then goes to the check, gcd and two reducing
// divides. Errors go straight to the output; unused commands pass the check only.
// A zero numerator skips the gcd and both reducing divides. s_tready returns in
// the same cycle that m_tvalid rises for the result.
// Synchronous reset clears the sequencer and m_tvalid. A stalled result holds
// in the output register; the sequencer waits in its last state for it.

module rational_arith_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16,
  localparam int IN_W = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // a_num, a_den, b_num, b_den
  input  logic [2:0]      s_tuser,   // command
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [63:0]     m_tdata,   // res_num, res_den
  output logic [1:0]      m_tuser    // status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int XW = (MW > 32) ? MW + 1 : 33;

  function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  state_t state, state_next;
  logic   go;

  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  logic [2:0]   cmd;
  logic         an_neg, ad_neg, bn_neg, bd_neg;
  logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic         den_gt, den_lt;
  logic [W-1:0] q1, r1, q2, r2;
  logic         common_neg;
  logic [MW-1:0] common_mag;
  logic [W-1:0] fa, fb;
  logic [MW-1:0] ta, tb;
  logic         ta_neg, tb_neg;
  logic         num_neg, den_neg;
  logic [MW-1:0] num_mag, den_mag, g;
  logic [1:0]   stat;

  logic [1:0]   in_stat;
  state_t       in_route;

  logic [W-1:0]  mul_x, mul_y;
  logic [MW-1:0] prod;
  logic          div_start, gcd_start;
  logic [MW-1:0] div_n, div_d, div_quo, div_rem, gcd_g;
  unit_stat_t    div_stat, gcd_stat;

  logic          use_a, use_b, bn_eff;
  logic          out_free;
  logic [XW-1:0] num_x, den_x, num_v, den_v;
  logic          fits;
  logic [1:0]    out_stat;

  assign in_an = s_tdata[W-1:0];
  assign in_ad = s_tdata[2*W-1:W];
  assign in_bn = s_tdata[3*W-1:2*W];
  assign in_bd = s_tdata[4*W-1:3*W];

  // decode the incoming request
  always_comb begin
    in_stat  = STAT_OK;
    in_route = S_CHECK;
    if (s_tuser == CMD_RECIP) begin
      if (in_ad == '0) begin
        in_stat  = STAT_ZERO_DEN;
        in_route = S_OUT;
      end else if (in_an == '0) begin
        in_stat  = STAT_ZERO_DIV;
        in_route = S_OUT;
      end
    end else if (s_tuser <= CMD_DIV) begin
      if (in_ad == '0 || in_bd == '0) begin
        in_stat  = STAT_ZERO_DEN;
        in_route = S_OUT;
      end else if (s_tuser == CMD_DIV && in_bn == '0) begin
        in_stat  = STAT_ZERO_DIV;
        in_route = S_OUT;
      end else if (s_tuser == CMD_MUL || s_tuser == CMD_DIV) begin
        in_route = S_MUL_N;
      end else begin
        in_route = S_DIV_AB;
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = in_route;
      S_DIV_AB: if (div_stat.done) state_next = S_DIV_BA;
      S_DIV_BA: if (div_stat.done) state_next = S_MUL_C;
      S_MUL_C:  state_next = S_MUL_TA;
      S_MUL_TA: state_next = S_MUL_TB;
      S_MUL_TB: state_next = S_SUM;
      S_SUM:    state_next = S_CHECK;
      S_MUL_N:  state_next = S_MUL_D;
      S_MUL_D:  state_next = S_CHECK;
      S_CHECK:  state_next = (num_mag == '0) ? S_OUT : S_GCD;
      S_GCD:    if (gcd_stat.done) state_next = S_DIV_N;
      S_DIV_N:  if (div_stat.done) state_next = S_DIV_D;
      S_DIV_D:  if (div_stat.done) state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    div_start = 1'b0;
    gcd_start = go && (state == S_GCD);
    div_n     = '0;
    div_d     = '0;
    mul_x     = '0;
    mul_y     = '0;
    case (state)
      S_DIV_AB: begin
        div_start = go;
        div_n     = MW'(ad_mag);
        div_d     = MW'(bd_mag);
      end
      S_DIV_BA: begin
        div_start = go;
        div_n     = MW'(bd_mag);
        div_d     = MW'(ad_mag);
      end
      S_DIV_N: begin
        div_start = go;
        div_n     = num_mag;
        div_d     = g;
      end
      S_DIV_D: begin
        div_start = go;
        div_n     = den_mag;
        div_d     = g;
      end
      S_MUL_C: begin
        mul_x = ad_mag;
        mul_y = bd_mag;
      end
      S_MUL_TA: begin
        mul_x = an_mag;
        mul_y = fa;
      end
      S_MUL_TB: begin
        mul_x = bn_mag;
        mul_y = fb;
      end
      S_MUL_N: begin
        mul_x = an_mag;
        mul_y = (cmd == CMD_MUL) ? bn_mag : bd_mag;
      end
      S_MUL_D: begin
        mul_x = ad_mag;
        mul_y = (cmd == CMD_MUL) ? bd_mag : bn_mag;
      end
      default: ;
    endcase
  end

  assign prod = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

  assign use_a  = den_gt && (r1 == '0);
  assign use_b  = den_lt && (r2 == '0);
  assign bn_eff = bn_neg ^ (cmd == CMD_SUB);

  // range check and two's complement form of the reduced result
  assign num_x = XW'(num_mag);
  assign den_x = XW'(den_mag);
  assign num_v = num_neg ? (XW'(0) - num_x) : num_x;
  assign den_v = den_neg ? (XW'(0) - den_x) : den_x;
  assign fits  = (num_neg ? (num_x <= (XW'(1) << 31)) : (num_x < (XW'(1) << 31))) &&
                 (den_neg ? (den_x <= (XW'(1) << 31)) : (den_x < (XW'(1) << 31)));
  assign out_stat = (stat != STAT_OK) ? stat : (fits ? STAT_OK : STAT_OVF);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      go       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      go    <= (state_next != state);
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (s_tvalid) begin
        cmd     <= s_tuser;
        an_neg  <= in_an[W-1];
        ad_neg  <= in_ad[W-1];
        bn_neg  <= in_bn[W-1];
        bd_neg  <= in_bd[W-1];
        an_mag  <= mag_of(in_an);
        ad_mag  <= mag_of(in_ad);
        bn_mag  <= mag_of(in_bn);
        bd_mag  <= mag_of(in_bd);
        den_gt  <= $signed(in_ad) > $signed(in_bd);
        den_lt  <= $signed(in_ad) < $signed(in_bd);
        stat    <= in_stat;
        if (s_tuser == CMD_RECIP) begin
          num_neg <= in_ad[W-1];
          num_mag <= MW'(mag_of(in_ad));
          den_neg <= in_an[W-1];
          den_mag <= MW'(mag_of(in_an));
        end else begin
          num_neg <= 1'b0;
          num_mag <= '0;
          den_neg <= 1'b0;
          den_mag <= MW'(1);
        end
      end
      S_DIV_AB: if (div_stat.done) begin
        q1 <= div_quo[W-1:0];
        r1 <= div_rem[W-1:0];
      end
      S_DIV_BA: if (div_stat.done) begin
        q2 <= div_quo[W-1:0];
        r2 <= div_rem[W-1:0];
      end
      S_MUL_C: begin
        if (use_a) begin
          common_neg <= ad_neg;
          common_mag <= MW'(ad_mag);
          fa         <= W'(1);
          fb         <= q1;
        end else if (use_b) begin
          common_neg <= bd_neg;
          common_mag <= MW'(bd_mag);
          fa         <= q2;
          fb         <= W'(1);
        end else begin
          common_neg <= ad_neg ^ bd_neg;
          common_mag <= prod;
          fa         <= bd_mag;
          fb         <= ad_mag;
        end
      end
      S_MUL_TA: begin
        ta     <= prod;
        ta_neg <= an_neg ^ common_neg ^ ad_neg;
      end
      S_MUL_TB: begin
        tb     <= prod;
        tb_neg <= bn_eff ^ common_neg ^ bd_neg;
      end
      S_SUM: begin
        den_neg <= common_neg;
        den_mag <= common_mag;
        if (ta_neg == tb_neg) begin
          num_neg <= ta_neg;
          num_mag <= ta + tb;
        end else if (ta >= tb) begin
          num_neg <= ta_neg;
          num_mag <= ta - tb;
        end else begin
          num_neg <= tb_neg;
          num_mag <= tb - ta;
        end
      end
      S_MUL_N: begin
        num_mag <= prod;
        num_neg <= an_neg ^ ((cmd == CMD_MUL) ? bn_neg : bd_neg);
      end
      S_MUL_D: begin
        den_mag <= prod;
        den_neg <= ad_neg ^ ((cmd == CMD_MUL) ? bd_neg : bn_neg);
      end
      S_CHECK: if (num_mag == '0) begin
        // zero numerator reads as 0/1
        num_neg <= 1'b0;
        den_neg <= 1'b0;
        den_mag <= MW'(1);
      end
      S_GCD:   if (gcd_stat.done) g <= gcd_g;
      S_DIV_N: if (div_stat.done) num_mag <= div_quo;
      S_DIV_D: if (div_stat.done) den_mag <= div_quo;
      S_OUT: if (out_free) begin
        m_tuser <= out_stat;
        if (out_stat == STAT_OK) begin
          m_tdata <= {den_v[RES_W-1:0], num_v[RES_W-1:0]};
        end else begin
          m_tdata <= '0;
        end
      end
      default: ;
    endcase
  end

  rau_div #(.W(MW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quo      (div_quo),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  rau_gcd #(.W(MW)) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .x_in  (num_mag),
    .y_in  (den_mag),
    .g     (gcd_g),
    .stat  (gcd_stat)
  );

  err_zero_a: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STAT_OK) |-> m_tdata == '0)
    else $error("error result carries nonzero fields");

  den_nonzero_a: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STAT_OK) |-> m_tdata[63:32] != '0)
    else $error("ok result with zero denominator");

  div_idle_a: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  gcd_idle_a: assert property (@(posedge clk) disable iff (rst)
    gcd_start |-> !gcd_stat.busy && num_mag != '0)
    else $error("gcd started while busy or on zero numerator");

endmodule

@@ verif/rau_checker.sv @@
// Result checker for the rational arithmetic unit: watches both stream channels,
// computes the reduced fraction for each request and compares it. Uses rau_pkg.
`timescale 1ns / 1ps

module rau_checker import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16,
  localparam int IN_W = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  input  logic [2:0]      s_tuser,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [63:0]     m_tdata,
  input  logic [1:0]      m_tuser,
  output int              errors,
  output int              pending
);

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic [1:0]  status;
  } fraction_t;

  fraction_t answers[$];

  function automatic longint sext(logic [OPERAND_WIDTH-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned mag_of(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Work in sign/magnitude like the hardware; signs are never normalized.
  function automatic fraction_t reduce_fraction(logic [2:0] cmd, logic [IN_W-1:0] d);
    longint an, ad, bn, bd, cd;
    bit nneg, dneg, tneg_a, tneg_b;
    longint unsigned nmag, dmag, ta, tb, x, y, t;
    fraction_t r;
    logic [1:0] st;
    an = sext(d[OPERAND_WIDTH-1:0]);
    ad = sext(d[2*OPERAND_WIDTH-1:OPERAND_WIDTH]);
    bn = sext(d[3*OPERAND_WIDTH-1:2*OPERAND_WIDTH]);
    bd = sext(d[4*OPERAND_WIDTH-1:3*OPERAND_WIDTH]);
    st = STAT_OK;
    nneg = 0; nmag = 0; dneg = 0; dmag = 1;
    if (cmd == CMD_RECIP) begin
      if (ad == 0) st = STAT_ZERO_DEN;
      else if (an == 0) st = STAT_ZERO_DIV;
      else begin
        nneg = ad < 0; nmag = mag_of(ad); dneg = an < 0; dmag = mag_of(an);
      end
    end else if (cmd <= CMD_DIV) begin
      if (ad == 0 || bd == 0) st = STAT_ZERO_DEN;
      else if (cmd == CMD_DIV && bn == 0) st = STAT_ZERO_DIV;
      else if (cmd == CMD_MUL) begin
        nneg = (an < 0) != (bn < 0); nmag = mag_of(an) * mag_of(bn);
        dneg = (ad < 0) != (bd < 0); dmag = mag_of(ad) * mag_of(bd);
      end else if (cmd == CMD_DIV) begin
        nneg = (an < 0) != (bd < 0); nmag = mag_of(an) * mag_of(bd);
        dneg = (ad < 0) != (bn < 0); dmag = mag_of(ad) * mag_of(bn);
      end else begin
        if (ad > bd && mag_of(ad) % mag_of(bd) == 0) cd = ad;
        else if (ad < bd && mag_of(bd) % mag_of(ad) == 0) cd = bd;
        else cd = ad * bd;
        tneg_a = (an < 0) != ((cd < 0) != (ad < 0));
        ta = mag_of(an) * (mag_of(cd) / mag_of(ad));
        tneg_b = ((bn < 0) != (cmd == CMD_SUB)) != ((cd < 0) != (bd < 0));
        tb = mag_of(bn) * (mag_of(cd) / mag_of(bd));
        if (tneg_a == tneg_b) begin
          nneg = tneg_a; nmag = ta + tb;
        end else if (ta >= tb) begin
          nneg = tneg_a; nmag = ta - tb;
        end else begin
          nneg = tneg_b; nmag = tb - ta;
        end
        dneg = cd < 0; dmag = mag_of(cd);
      end
    end
    if (st == STAT_OK) begin
      if (nmag == 0) begin
        nneg = 0; dneg = 0; dmag = 1;
      end else begin
        x = nmag; y = dmag;
        while (y != 0) begin
          t = x % y; x = y; y = t;
        end
        nmag /= x; dmag /= x;
        if (nmag > (nneg ? 64'h8000_0000 : 64'h7FFF_FFFF) ||
            dmag > (dneg ? 64'h8000_0000 : 64'h7FFF_FFFF)) st = STAT_OVF;
      end
    end
    r.status = st;
    if (st != STAT_OK) begin
      r.num = '0; r.den = '0;
    end else begin
      r.num = nneg ? 32'(-nmag) : 32'(nmag);
      r.den = dneg ? 32'(-dmag) : 32'(dmag);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    fraction_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) answers.push_back(reduce_fraction(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (answers.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], '0);
        end else begin
          want = answers.pop_front();
          if (m_tdata[31:0] !== want.num) report_mismatch("res_num", m_tdata[31:0], want.num);
          if (m_tdata[63:32] !== want.den)
            report_mismatch("res_den", m_tdata[63:32], want.den);
          if (m_tuser !== want.status)
            report_mismatch("status", 32'(m_tuser), 32'(want.status));
        end
      end
    end
    pending = answers.size();
  end

endmodule

@@ verif/testbench.sv @@
// Stimulus and verdict for the rational arithmetic unit.
// Depends on rau_pkg, rational_arith_unit and rau_checker.
`timescale 1ns / 1ps

module testbench;
  import rau_pkg::*;

  localparam int OW = 16;
  localparam int IN_W = ((4 * OW + 7) / 8) * 8;
  localparam int N_RANDOM = 730;
  localparam int LIMIT = 2_000_000;

  logic            clk = 0;
  logic            rst = 1;
  logic            s_tvalid = 0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [2:0]      s_tuser = '0;
  logic            m_tvalid;
  logic            m_tready = 0;
  logic [63:0]     m_tdata;
  logic [1:0]      m_tuser;
  int              errors, pending;
  int              sent = 0;
  int              cycles = 0;
  bit              quiet = 0;
  bit              hold_off = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  rational_arith_unit #(.OPERAND_WIDTH(OW)) dut (.*);

  rau_checker #(.OPERAND_WIDTH(OW)) checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none at the end.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        m_tready <= 1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // Leaves s_tvalid high on return; the caller drops it before any pause.
  task automatic send_request(logic [2:0] cmd, logic [OW-1:0] an, logic [OW-1:0] ad,
                              logic [OW-1:0] bn, logic [OW-1:0] bd);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {bd, bn, ad, an};
    do @(posedge clk); while (!(s_tready && s_tvalid));
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [OW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return OW'($urandom_range(1, 9));
      2: return -OW'($urandom_range(1, 9));
      3: return {1'b1, {(OW-1){1'b0}}};
      4: return {1'b0, {(OW-1){1'b1}}};
      5: return OW'($urandom_range(1, 4)) * OW'(1 << $urandom_range(0, 8));
      default: return OW'($urandom);
    endcase
  endfunction

  initial begin
    logic [OW-1:0] mx, mn;
    logic [2:0] cmd;
    mx = {1'b0, {(OW-1){1'b1}}};
    mn = {1'b1, {(OW-1){1'b0}}};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Directed: each command, extremes, zero denominators, zero divisors, unused codes.
    send_request(CMD_ADD, 1, 2, 1, 3);
    send_request(CMD_ADD, 1, 4, 1, 2);
    send_request(CMD_ADD, 1, -2, 1, 4);
    send_request(CMD_SUB, 1, 2, 1, 2);
    send_request(CMD_SUB, 3, 4, -1, 6);
    send_request(CMD_MUL, mn, mn, mn, mn);
    send_request(CMD_MUL, mn, 1, mn, 1);
    send_request(CMD_MUL, mx, 1, mx, -1);
    send_request(CMD_DIV, 2, 3, 4, 5);
    send_request(CMD_DIV, 2, 3, 0, 5);
    send_request(CMD_DIV, 1, 0, 0, 5);
    send_request(CMD_RECIP, -3, 7, 0, 0);
    send_request(CMD_RECIP, 0, 7, 1, 1);
    send_request(CMD_RECIP, 0, 0, 1, 1);
    send_request(CMD_ADD, 5, 1, 5, 0);
    send_request(CMD_ADD, mx, mn, mx, mx);
    send_request(CMD_SUB, mn, mx, mx, mn);
    send_request(CMD_ADD, '1, '1, '1, '1);
    send_request(CMD_SUB, mn, 1, mx, 1);
    send_request(CMD_MUL, 0, 5, 7, 3);
    send_request(3'd5, 1, 2, 3, 4);
    send_request(3'd6, mn, 0, mx, 0);
    send_request(3'd7, '1, '1, '1, '1);
    // Long receiver hold-off while requests keep coming.
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      begin
        repeat (4) send_request(CMD_MUL, pick_value(), 3, pick_value(), 5);
        s_tvalid <= 0;
      end
    join
    // Sender pause until every result has drained.
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 80) quiet = 1;
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      send_request(cmd, pick_value(), pick_value(), pick_value(), pick_value());
    end
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
